[rtl/centered_image_stack_accumulator_top_macros.svh]
// Assertion macros used by the stack accumulator top level.
`ifndef CENTERED_IMAGE_STACK_ACCUMULATOR_TOP_MACROS_SVH
`define CENTERED_IMAGE_STACK_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, clocked on aclk and disabled during reset.
`define CSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, clocked on aclk and disabled during reset.
`define CSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/csa_pkg.sv]
// Shared types and constants of the centered image stack accumulator.
`default_nettype none

package csa_pkg;

    // Default frame geometry.
    localparam int FRAME_W_DEF = 512;
    localparam int FRAME_H_DEF = 512;

    // Field widths.
    localparam int COL_W   = 9;
    localparam int ROW_W   = 9;
    localparam int PIX_W   = 8;
    localparam int CTR_W   = 13;
    localparam int COORD_W = 10;
    localparam int EXT_W   = 10;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [EXT_W-1:0] EXT_MAX = 10'd1023;

    // Request kinds carried in s_tuser.
    typedef enum logic [1:0] {
        MODE_ACCUM  = 2'd0,
        MODE_READ   = 2'd1,
        MODE_RDCLR  = 2'd2,
        MODE_RSTEXT = 2'd3
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_CENTERING = 2'd0,
        CFG_REF_X     = 2'd1,
        CFG_REF_Y     = 2'd2
    } cfg_idx_t;

    // Target position of one request after alignment.
    typedef struct packed {
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic               in_frame;
    } csa_target_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_ADDR  = 2'd2,
        ST_MOD   = 2'd3
    } csa_state_t;

endpackage

`default_nettype wire

[rtl/centered_image_stack_accumulator_top.sv]
// Top level of the centered image stack accumulator.
//
// Requests arrive on the s_ stream: s_tuser carries the mode (accumulate, read,
// read and clear, reset extents), s_tdata the pixel position, intensity and the
// image mass center. Each request yields exactly one result on the m_ stream
// with the pixel value, the current aggregate extents and a dropped flag.
// Registers are written through the cfg_ channel, which is always ready.
// After reset the frame buffer is swept to zero, one entry per cycle, across
// all FRAME_W * FRAME_H entries (262144 at the default size); no request is
// taken during the sweep, while configuration writes are.
// A request passes through capture with the alignment shift, memory read,
// then modify and write back, and the result is registered at the end of the
// write-back step; a new request is taken only once the last has left it.
// The result sits in an output register, so the next request is accepted while
// it waits; if the receiver stalls, the following request holds in the
// write-back step until the output register is free.
`default_nettype none

`include "centered_image_stack_accumulator_top_macros.svh"

module centered_image_stack_accumulator_top #(
    parameter int FRAME_W = csa_pkg::FRAME_W_DEF,
    parameter int FRAME_H = csa_pkg::FRAME_H_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // col[8:0], row[17:9], pixel[25:18],
                                       // center_x[38:26], center_y[51:39], zero pad
    input  wire logic [1:0]  s_tuser,  // mode[1:0]
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // read_value[7:0], extent_width[17:8],
                                       // extent_height[27:18], zero pad
    output logic [0:0]       m_tuser,  // dropped[0]
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [12:0] cfg_wdata
);

    localparam int DEPTH  = FRAME_W * FRAME_H;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // Sequencer and storage signals.
    csa_pkg::csa_state_t state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;

    logic                         centering_reg;
    logic [csa_pkg::CTR_W-1:0]    ref_x_reg;
    logic [csa_pkg::CTR_W-1:0]    ref_y_reg;

    csa_pkg::mode_t               mode_reg;
    csa_pkg::csa_target_t         tgt_reg;
    csa_pkg::csa_target_t         tgt_next;
    logic [csa_pkg::PIX_W-1:0]    pixel_reg;
    logic [ADDR_W-1:0]            addr_reg, addr_next;

    logic [csa_pkg::EXT_W-1:0]    ext_w_reg, ext_w_next;
    logic [csa_pkg::EXT_W-1:0]    ext_h_reg, ext_h_next;

    logic                         out_valid_reg;
    logic [csa_pkg::PIX_W-1:0]    out_value_reg, out_value_next;
    logic                         out_drop_reg, out_drop_next;
    logic [csa_pkg::EXT_W-1:0]    out_w_reg, out_h_reg;

    logic                         s_accept;
    logic                         out_free;
    logic                         out_load;
    logic                         mem_we, mem_re;
    logic [ADDR_W-1:0]            mem_waddr;
    logic [csa_pkg::PIX_W-1:0]    mem_wdata, mem_rdata;
    logic [csa_pkg::PIX_W:0]      sum_wide;
    logic [csa_pkg::PIX_W-1:0]    sum_sat;
    logic                         is_accum, is_read, is_rdclr, is_rstext;

    // Grow an extent to cover a written position, saturating at the maximum.
    function automatic logic [csa_pkg::EXT_W-1:0] grow(
        input logic [csa_pkg::EXT_W-1:0]   cur,
        input logic [csa_pkg::COORD_W-1:0] pos
    );
        logic [csa_pkg::COORD_W:0] n;
        logic [csa_pkg::EXT_W-1:0] nc;
        begin
            n  = {1'b0, pos} + (csa_pkg::COORD_W+1)'(1);
            nc = (n > {1'b0, csa_pkg::EXT_MAX}) ? csa_pkg::EXT_MAX : n[csa_pkg::EXT_W-1:0];
            return (nc > cur) ? nc : cur;
        end
    endfunction

    // Alignment and bounds check on the incoming request.
    csa_target #(
        .FRAME_W (FRAME_W),
        .FRAME_H (FRAME_H)
    ) u_target (
        .mode         (csa_pkg::mode_t'(s_tuser[1:0])),
        .col          (s_tdata[8:0]),
        .row          (s_tdata[17:9]),
        .center_x     (s_tdata[38:26]),
        .center_y     (s_tdata[51:39]),
        .centering_on (centering_reg),
        .ref_center_x (ref_x_reg),
        .ref_center_y (ref_y_reg),
        .tgt          (tgt_next)
    );

    // Frame buffer.
    csa_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (csa_pkg::PIX_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr_next),
        .rdata (mem_rdata)
    );

    // Request decode of the held item.
    assign is_accum  = (mode_reg == csa_pkg::MODE_ACCUM);
    assign is_read   = (mode_reg == csa_pkg::MODE_READ);
    assign is_rdclr  = (mode_reg == csa_pkg::MODE_RDCLR);
    assign is_rstext = (mode_reg == csa_pkg::MODE_RSTEXT);

    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Linear buffer address of the held target.
    assign addr_next = ADDR_W'(tgt_reg.ty) * ADDR_W'(FRAME_W) + ADDR_W'(tgt_reg.tx);

    // Saturating add of the stored pixel and the incoming intensity.
    assign sum_wide = {1'b0, mem_rdata} + {1'b0, pixel_reg};
    assign sum_sat  = sum_wide[csa_pkg::PIX_W] ? csa_pkg::PIX_MAX
                                               : sum_wide[csa_pkg::PIX_W-1:0];

    // Next state.
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            csa_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = csa_pkg::ST_IDLE;
                end
            end
            csa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = csa_pkg::ST_ADDR;
                end
            end
            csa_pkg::ST_ADDR: begin
                state_next = csa_pkg::ST_MOD;
            end
            csa_pkg::ST_MOD: begin
                if (out_free) begin
                    state_next = csa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = csa_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and memory controls.
    always_comb begin
        s_tready  = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        out_load  = 1'b0;
        unique case (state_reg)
            csa_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            csa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            csa_pkg::ST_ADDR: begin
                mem_re = 1'b1;
            end
            csa_pkg::ST_MOD: begin
                out_load  = out_free;
                mem_we    = out_free && tgt_reg.in_frame && (is_accum || is_rdclr);
                mem_wdata = is_accum ? sum_sat : '0;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Result value, dropped flag and extents after the step.
    always_comb begin
        out_value_next = '0;
        out_drop_next  = 1'b0;
        ext_w_next     = ext_w_reg;
        ext_h_next     = ext_h_reg;
        if (is_rstext) begin
            ext_w_next = '0;
            ext_h_next = '0;
        end else if (!tgt_reg.in_frame) begin
            out_drop_next = 1'b1;
        end else if (is_accum) begin
            out_value_next = sum_sat;
            ext_w_next     = grow(ext_w_reg, tgt_reg.tx);
            ext_h_next     = grow(ext_h_reg, tgt_reg.ty);
        end else if (is_read || is_rdclr) begin
            out_value_next = mem_rdata;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= csa_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            ext_w_reg     <= '0;
            ext_h_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
                ext_w_reg     <= ext_w_next;
                ext_h_reg     <= ext_h_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centering_reg <= 1'b0;
            ref_x_reg     <= '0;
            ref_y_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                csa_pkg::CFG_CENTERING: centering_reg <= cfg_wdata[0];
                csa_pkg::CFG_REF_X:     ref_x_reg     <= cfg_wdata;
                csa_pkg::CFG_REF_Y:     ref_y_reg     <= cfg_wdata;
                default:                centering_reg <= centering_reg;
            endcase
        end
    end

    // Payload registers of the held request and of the result.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg  <= csa_pkg::mode_t'(s_tuser[1:0]);
            tgt_reg   <= tgt_next;
            pixel_reg <= s_tdata[25:18];
        end
        if (state_reg == csa_pkg::ST_ADDR) begin
            addr_reg <= addr_next;
        end
        if (out_load) begin
            out_value_reg <= out_value_next;
            out_drop_reg  <= out_drop_next;
            out_w_reg     <= ext_w_next;
            out_h_reg     <= ext_h_next;
        end
    end

    // Result stream.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_h_reg, out_w_reg, out_value_reg};
    assign m_tuser  = out_drop_reg;

    // An accepted request moves on to the memory read.
    `CSA_ASSERT_NEXT(a_accept_to_addr, s_accept, state_reg == csa_pkg::ST_ADDR)
    // Write-back only lands inside the frame.
    `CSA_ASSERT_NOW(a_write_in_frame, mem_we && (state_reg == csa_pkg::ST_MOD),
        tgt_reg.in_frame)
    // Finishing a request presents a result.
    `CSA_ASSERT_NEXT(a_mod_done_valid,
        (state_reg == csa_pkg::ST_MOD) && (state_next == csa_pkg::ST_IDLE), m_tvalid)
    // A dropped request reports a zero value.
    `CSA_ASSERT_NOW(a_drop_zero, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'd0)

endmodule

`default_nettype wire

[rtl/csa_mem.sv]
// Frame buffer memory: one write port and one registered read port.
`default_nettype none

module csa_mem #(
    parameter int DEPTH  = csa_pkg::FRAME_W_DEF * csa_pkg::FRAME_H_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = csa_pkg::PIX_W
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/csa_target.sv]
// Alignment shift and frame bounds check for one incoming request.
`default_nettype none

module csa_target #(
    parameter int FRAME_W = csa_pkg::FRAME_W_DEF,
    parameter int FRAME_H = csa_pkg::FRAME_H_DEF
) (
    input  wire csa_pkg::mode_t                 mode,
    input  wire logic [csa_pkg::COL_W-1:0]      col,
    input  wire logic [csa_pkg::ROW_W-1:0]      row,
    input  wire logic [csa_pkg::CTR_W-1:0]      center_x,
    input  wire logic [csa_pkg::CTR_W-1:0]      center_y,
    input  wire logic                           centering_on,
    input  wire logic [csa_pkg::CTR_W-1:0]      ref_center_x,
    input  wire logic [csa_pkg::CTR_W-1:0]      ref_center_y,
    output csa_pkg::csa_target_t                tgt
);

    // Ceiling of (reference - center) / 16, zero when the difference is not positive.
    function automatic logic [csa_pkg::COORD_W-1:0] axis_shift(
        input logic [csa_pkg::CTR_W-1:0] r_ctr,
        input logic [csa_pkg::CTR_W-1:0] i_ctr
    );
        logic [csa_pkg::CTR_W:0] d;
        begin
            d = {1'b0, r_ctr - i_ctr} + (csa_pkg::CTR_W+1)'(15);
            if (r_ctr <= i_ctr) begin
                return '0;
            end
            return d[csa_pkg::CTR_W:4];
        end
    endfunction

    logic                        shift_en;
    logic [csa_pkg::COORD_W-1:0] shift_x;
    logic [csa_pkg::COORD_W-1:0] shift_y;

    // Only accumulate requests are moved, and only with centering enabled.
    assign shift_en = centering_on && (mode == csa_pkg::MODE_ACCUM);
    assign shift_x  = shift_en ? axis_shift(ref_center_x, center_x) : '0;
    assign shift_y  = shift_en ? axis_shift(ref_center_y, center_y) : '0;

    // Target position and frame check.
    always_comb begin
        tgt.tx       = csa_pkg::COORD_W'(col) + shift_x;
        tgt.ty       = csa_pkg::COORD_W'(row) + shift_y;
        tgt.in_frame = (32'(tgt.tx) < 32'(FRAME_W)) && (32'(tgt.ty) < 32'(FRAME_H));
    end

endmodule

`default_nettype wire
